/* src/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants of the linear blend skinning unit
// ----------------------------------------------------------------------------
`default_nettype none
package lbs_pkg;
   localparam int BoneCountDefault = 128;
   localparam int WordWidthDefault = 32;
   localparam int MatWords = 12;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_INFLUENCE = 2'd1,
      KIND_PASS = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] bone_index;
      logic [3:0] element_index;
      logic signed [31:0] matrix_word;
      logic [15:0] weight;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic last_influence;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_norm_x;
      logic signed [31:0] out_norm_y;
      logic signed [31:0] out_norm_z;
   } rsp_type;

   // saturate a 50-bit value to the signed 48-bit range
   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [49:0] hi;
      logic signed [49:0] lo;
      hi = 50'sh0_7FFF_FFFF_FFFF;
      lo = -50'sh0_8000_0000_0000;
      if (v > hi) return 48'sh7FFF_FFFF_FFFF;
      else if (v < lo) return -48'sh8000_0000_0000;
      else return v[47:0];
   endfunction

   // saturate a 48-bit value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
      else return v[31:0];
   endfunction
endpackage
`default_nettype wire

/* src/lbs_if.sv */
// ----------------------------------------------------------------------------
// lbs_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface lbs_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/lbs_mac.sv */
// ----------------------------------------------------------------------------
// lbs_mac
// one row term: matrix word times vector component, floored by 2^16
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_mac import lbs_pkg::*; (
   input wire logic clock,
   input wire logic signed [31:0] a,
   input wire logic signed [31:0] b,
   output logic signed [47:0] prod_ff
);
   logic signed [63:0] prod_in;
   // arithmetic shift floors
   assign prod_in = a * b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:16];
   end
endmodule
`default_nettype wire

/* src/linear_blend_skinning.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// linear_blend_skinning
// bone palette skinning with weighted accumulation of position and normal
// ----------------------------------------------------------------------------
// Usage: req is the input channel (palette writes, influences, passthrough
// vertices), rsp carries one result per finished vertex.
// The palette is a 12*BONE_COUNT word synchronous memory with one read port.
// An influence walks its three matrix rows: for each of 4 words of a row
// a memory read state and a multiply state, then a row sum state and a
// weight/accumulate state. After the third row an influence passes ST_OUT,
// where a last influence has its result registered, and then returns to
// idle; no new item is accepted before that. A palette write is stored at
// accept; a passthrough result is registered at accept and valid in the
// cycle after. The single memory read port and the two position/normal
// multipliers set this sequence. Items are handled one at a time.
// Reset clears the accumulators and control; the palette holds no valid
// bits and reads garbage until written. A finished result waits in the rsp
// register; while it waits no new item is accepted.
// ----------------------------------------------------------------------------
module linear_blend_skinning import lbs_pkg::*; #(
   parameter int BONE_COUNT = BoneCountDefault,
   parameter int WORD_WIDTH = WordWidthDefault
) (
   input wire logic clock,
   input wire logic reset,
   lbs_if.sink req,
   lbs_if.source rsp
);
   localparam int Depth = BONE_COUNT * MatWords;
   localparam int AddrW = $clog2(Depth);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MUL = 6'b000100,
      ST_ROW = 6'b001000,
      ST_WGT = 6'b010000,
      ST_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type item_ff;
   logic [3:0] elem_ff;
   logic [1:0] row_ff;
   logic valid_bone_ff;
   logic signed [31:0] mem [Depth];
   logic signed [31:0] rd_ff;
   logic signed [47:0] prod;
   logic signed [49:0] tp_ff, tn_ff;
   logic signed [31:0] tp32_ff, tn32_ff;
   logic signed [47:0] pacc_ff [3];
   logic signed [47:0] nacc_ff [3];
   logic signed [63:0] wp, wn;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic signed [31:0] word_ext;
   logic [AddrW-1:0] waddr, raddr;
   logic signed [31:0] vec_sel;
   logic signed [31:0] mat_op;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // palette write and read
   assign word_ext = 32'(signed'(req.data.matrix_word[WORD_WIDTH-1:0]));
   assign waddr = AddrW'(req.data.bone_index * MatWords + req.data.element_index);
   assign raddr = AddrW'(item_ff.bone_index * MatWords + elem_ff);
   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.data.kind == KIND_WRITE
          && 32'(req.data.bone_index) < BONE_COUNT && req.data.element_index < 4'(MatWords))
         mem[waddr] <= word_ext;
      rd_ff <= mem[raddr];
   end

   // operand select: column 0..2 multiplies the vector, column 3 is translation
   always_comb begin
      case (elem_ff[1:0])
         2'd0: vec_sel = item_ff.pos_x;
         2'd1: vec_sel = item_ff.pos_y;
         default: vec_sel = item_ff.pos_z;
      endcase
      mat_op = valid_bone_ff ? rd_ff : '0;
   end

   logic signed [31:0] nvec_sel;
   always_comb begin
      case (elem_ff[1:0])
         2'd0: nvec_sel = item_ff.norm_x;
         2'd1: nvec_sel = item_ff.norm_y;
         default: nvec_sel = item_ff.norm_z;
      endcase
   end

   logic signed [47:0] nprod;
   lbs_mac u_mac_p (.clock(clock), .a(mat_op), .b(vec_sel), .prod_ff(prod));
   lbs_mac u_mac_n (.clock(clock), .a(mat_op), .b(nvec_sel), .prod_ff(nprod));

   // weight products of the saturated row sums
   assign wp = tp32_ff * $signed({1'b0, item_ff.weight});
   assign wn = tn32_ff * $signed({1'b0, item_ff.weight});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid && req.ready && req.data.kind == KIND_INFLUENCE)
            state_in = ST_READ;
         ST_READ: state_in = ST_MUL;
         ST_MUL: state_in = (elem_ff[1:0] == 2'd3) ? ST_ROW : ST_READ;
         ST_ROW: state_in = ST_WGT;
         ST_WGT: state_in = (row_ff == 2'd2) ? ST_OUT : ST_READ;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: accept, read word, multiply, add to row sum; per row weight and accumulate; output
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pacc_ff[i] <= '0;
            nacc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  item_ff <= req.data;
                  elem_ff <= '0;
                  row_ff <= '0;
                  tp_ff <= '0;
                  tn_ff <= '0;
                  valid_bone_ff <= 32'(req.data.bone_index) < BONE_COUNT;
                  if (req.data.kind == KIND_PASS) begin
                     rsp_ff <= {req.data.pos_x, req.data.pos_y, req.data.pos_z,
                                req.data.norm_x, req.data.norm_y, req.data.norm_z};
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               // product registered this cycle, summed in the next ST_READ; the column 3 product is not used
               elem_ff <= elem_ff + 4'd1;
            end
            ST_READ: begin
               if (elem_ff[1:0] != 2'd0) begin
                  tp_ff <= tp_ff + 50'(prod);
                  tn_ff <= tn_ff + 50'(nprod);
               end
            end
            ST_ROW: begin
               // translation word is rd_ff of column 3; normal ignores it
               tp32_ff <= sat32(sat48(tp_ff + 50'(mat_op)));
               tn32_ff <= sat32(sat48(tn_ff));
            end
            ST_WGT: begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) == row_ff) begin
                     pacc_ff[i] <= sat48(50'(pacc_ff[i]) + 50'($signed(wp[63:15])));
                     nacc_ff[i] <= sat48(50'(nacc_ff[i]) + 50'($signed(wn[63:15])));
                  end
               end
               row_ff <= row_ff + 2'd1;
               tp_ff <= '0;
               tn_ff <= '0;
            end
            ST_OUT: begin
               if (item_ff.last_influence) begin
                  rsp_ff <= {sat32(pacc_ff[0]), sat32(pacc_ff[1]), sat32(pacc_ff[2]),
                             sat32(nacc_ff[0]), sat32(nacc_ff[1]), sat32(nacc_ff[2])};
                  rsp_valid_ff <= 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     pacc_ff[i] <= '0;
                     nacc_ff[i] <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_noaccept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_out_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && item_ff.last_influence) |=> (pacc_ff[0] == '0))
      else $error("accumulator not cleared");
`endif
endmodule
`default_nettype wire
